FILE: hw/rtl/dido_pkg.sv
// ----------------------------------------------------------------------------
// dido_pkg
// Shared types and constants of the digraph in/out-degree filter.
// ----------------------------------------------------------------------------
package dido_pkg;

	localparam int IDX_OUT_W = 5;   // vertex_index port width
	localparam int MEAN_W    = 14;  // mean_degree port width
	localparam int CNT_OUT_W = 6;   // match_count port width
	localparam int WEIGHT_W  = 8;   // edge_weight port width
	localparam int VC_W      = 6;   // vertex_count register width
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	// vertex capacity; the result port widths are sized for it
	localparam int MAX_VERTEX_COUNT = 32;
	localparam int IDX_W            = $clog2(MAX_VERTEX_COUNT);
	localparam int SUM_W            = $clog2(MAX_VERTEX_COUNT * 255 + 1);
	localparam int CNT_W            = $clog2(MAX_VERTEX_COUNT + 1);

	localparam logic            REG_VERTEX_COUNT = 1'b0;
	localparam logic [VC_W-1:0] VC_RESET         = 6'd32;

	typedef enum logic [4:0] {
		S_ACCUM = 5'b00001,
		S_FLUSH = 5'b00010,
		S_READ  = 5'b00100,
		S_EVAL  = 5'b01000,
		S_FIN   = 5'b10000
	} dido_state_t;

	typedef struct packed {
		logic accept;       // take one matrix entry
		logic walk_start;   // rewind walk index, clear found count
		logic walk_rd;      // read both sums at walk index
		logic advance;      // step walk index
		logic emit_vertex;  // load a vertex result
		logic emit_end;     // load the end result
	} dido_cmd_t;

	typedef struct packed {
		logic last_item;    // next entry completes the matrix
		logic qual;         // out-degree below in-degree at walk index
		logic walk_last;    // walk index is the last vertex
		logic out_free;     // result register can take a new item
	} dido_sts_t;

endpackage

FILE: hw/rtl/dido_ctrl.sv
// ----------------------------------------------------------------------------
// dido_ctrl
// Sequencer: accumulates entries, then walks the vertices and emits results.
// ----------------------------------------------------------------------------
module dido_ctrl
	import dido_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr,
	input  logic      edge_valid,
	output logic      edge_stall,
	input  dido_sts_t sts,
	output dido_cmd_t cmd
);

	dido_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		edge_stall = 1'b1;
		case (state_q)
			S_ACCUM: begin
				edge_stall = 1'b0;
				cmd.accept = edge_valid;
				if (edge_valid && sts.last_item) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// last entry's sums land in memory this cycle
				cmd.walk_start = 1'b1;
				state_d        = S_READ;
			end
			S_READ: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				if (!sts.qual || sts.out_free) begin
					cmd.emit_vertex = sts.qual;
					if (sts.walk_last) begin
						state_d = S_FIN;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = S_ACCUM;
				end
			end
			default: begin
				state_d = S_ACCUM;
			end
		endcase
		if (cfg_wr) begin
			state_d = S_ACCUM;
		end
	end

endmodule

FILE: hw/rtl/dido_dpath.sv
// ----------------------------------------------------------------------------
// dido_dpath
// Degree sums in two memories, entry counters, walk index and result register.
// ----------------------------------------------------------------------------
module dido_dpath
	import dido_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr,
	input  logic [IDX_W-1:0]         n_m1,
	input  logic [WEIGHT_W-1:0]      edge_weight,
	input  dido_cmd_t                cmd,
	output dido_sts_t                sts,
	input  logic                     result_stall,
	output logic                     result_valid,
	output logic [IDX_OUT_W-1:0]     vertex_index,
	output logic [MEAN_W-1:0]        mean_degree,
	output logic                     end_of_list,
	output logic [CNT_OUT_W-1:0]     match_count
);

	logic [SUM_W-1:0]    out_mem [MAX_VERTEX_COUNT];
	logic [SUM_W-1:0]    in_mem  [MAX_VERTEX_COUNT];

	logic [IDX_W-1:0]    row_q, col_q, walk_idx_q;
	logic [CNT_W-1:0]    found_q;
	logic                valid_s1;
	logic [WEIGHT_W-1:0] w_s1;
	logic [IDX_W-1:0]    row_s1, col_s1;
	logic [SUM_W-1:0]    row_acc_q;
	logic [SUM_W-1:0]    in_rd_q, out_rd_q;
	logic [IDX_W-1:0]    in_raddr;
	logic [SUM_W-1:0]    in_new, row_new;
	logic                row_end_s1;
	logic [SUM_W:0]      both_sum;

	assign in_raddr   = cmd.walk_rd ? walk_idx_q : col_q;
	assign row_end_s1 = (col_s1 == n_m1);

	// row 0 starts every column sum afresh, so no clearing pass is needed
	assign in_new  = (row_s1 == '0) ? SUM_W'(w_s1) : in_rd_q + SUM_W'(w_s1);
	assign row_new = (col_s1 == '0) ? SUM_W'(w_s1) : row_acc_q + SUM_W'(w_s1);

	assign both_sum = {1'b0, out_rd_q} + {1'b0, in_rd_q};

	assign sts.last_item = (row_q == n_m1) && (col_q == n_m1);
	assign sts.qual      = (out_rd_q < in_rd_q);
	assign sts.walk_last = (walk_idx_q == n_m1);
	assign sts.out_free  = !result_valid || !result_stall;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			in_mem[col_s1] <= in_new;
			if (row_end_s1) begin
				out_mem[row_s1] <= row_new;
			end
		end
		if (cmd.accept || cmd.walk_rd) begin
			in_rd_q <= in_mem[in_raddr];
		end
		if (cmd.walk_rd) begin
			out_rd_q <= out_mem[walk_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_s1   <= edge_weight;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
		if (valid_s1) begin
			row_acc_q <= row_new;
		end
		if (cmd.emit_vertex) begin
			vertex_index <= IDX_OUT_W'(walk_idx_q);
			mean_degree  <= MEAN_W'(both_sum);
			end_of_list  <= 1'b0;
			match_count  <= '0;
		end else if (cmd.emit_end) begin
			vertex_index <= '0;
			mean_degree  <= '0;
			end_of_list  <= 1'b1;
			match_count  <= CNT_OUT_W'(found_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			col_q        <= '0;
			walk_idx_q   <= '0;
			found_q      <= '0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			if (cfg_wr) begin
				row_q    <= '0;
				col_q    <= '0;
				found_q  <= '0;
				valid_s1 <= 1'b0;
			end else if (cmd.accept) begin
				if (col_q == n_m1) begin
					col_q <= '0;
					row_q <= (row_q == n_m1) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.walk_start) begin
				walk_idx_q <= '0;
				found_q    <= '0;
			end else begin
				if (cmd.advance) begin
					walk_idx_q <= walk_idx_q + 1'b1;
				end
				if (cmd.emit_vertex) begin
					found_q <= found_q + 1'b1;
				end
			end
			if (cmd.emit_vertex || cmd.emit_end) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_vertex || cmd.emit_end) |-> sts.out_free)
		else $error("result loaded while previous result still stalled");

	a_emit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_vertex && cmd.emit_end))
		else $error("vertex and end result loaded together");

	a_end_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |=> (result_valid && end_of_list))
		else $error("end result not presented");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> (walk_idx_q <= n_m1))
		else $error("walk index beyond vertex count");
`endif

endmodule

FILE: hw/rtl/digraph_in_out_degree_filter.sv
// Matrix entries transfer at one per cycle, entry after entry, while the block accumulates.
// After the last entry: a flush state, then per vertex a sum memory read and a compare
// (the compare waits while a qualifying result meets a stalled output), then the end result.
// No entry is taken during that vertex walk; the first entry of the next matrix may
// transfer while the end result still waits. Reset: vertex_count = 32, counters cleared;
// the sum memories are not cleared, since the first row of each matrix overwrites them.
// ----------------------------------------------------------------------------
// digraph_in_out_degree_filter
// Top level: register port, effective vertex count, controller and datapath.
// ----------------------------------------------------------------------------
module digraph_in_out_degree_filter
	import dido_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  edge_valid,
	output logic                  edge_stall,
	input  logic [WEIGHT_W-1:0]   edge_weight,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [IDX_OUT_W-1:0]  vertex_index,
	output logic [MEAN_W-1:0]     mean_degree,
	output logic                  end_of_list,
	output logic [CNT_OUT_W-1:0]  match_count
);

	logic [VC_W-1:0]  vc_q;
	logic [VC_W-1:0]  n_eff;
	logic [IDX_W-1:0] n_m1;
	logic             cfg_wr;
	logic             reg_sel;
	dido_cmd_t        cmd;
	dido_sts_t        sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_sel == REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (cfg_wr) begin
			vc_q <= pwdata[VC_W-1:0];
		end
	end

	always_comb begin
		case (reg_sel)
			REG_VERTEX_COUNT: prdata = {{(APB_DW-VC_W){1'b0}}, vc_q};
			default:          prdata = '0;
		endcase
	end

	// zero acts as one; anything above the capacity is clamped
	always_comb begin
		if (vc_q == '0) begin
			n_eff = VC_W'(1);
		end else if (vc_q > VC_W'(MAX_VERTEX_COUNT)) begin
			n_eff = VC_W'(MAX_VERTEX_COUNT);
		end else begin
			n_eff = vc_q;
		end
	end
	assign n_m1 = IDX_W'(n_eff - 1'b1);

	dido_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.edge_valid (edge_valid),
		.edge_stall (edge_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dido_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.n_m1         (n_m1),
		.edge_weight  (edge_weight),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.vertex_index (vertex_index),
		.mean_degree  (mean_degree),
		.end_of_list  (end_of_list),
		.match_count  (match_count)
	);

endmodule
